FILE: rtl/ft4d_pkg.sv
// shared types, constants and helpers of the 4d fold transform step
`default_nettype none
package ft4d_pkg;

	typedef logic signed [31:0] q_t;

	localparam q_t Q_MAX = q_t'(32'h7FFFFFFF);
	localparam q_t Q_MIN = q_t'(32'h80000000);

	localparam int SQ_STEPS  = 31;
	localparam int DIV_STEPS = 32;

	localparam int MF_LENGTH = 0;
	localparam int MF_CONST  = 1;
	localparam int MF_ZERO   = 2;
	localparam int MF_NOTWK  = 3;
	localparam int MF_MULT   = 4;

	typedef enum logic [2:0] {
		CFG_WINDOW      = 3'd0,
		CFG_MODE        = 3'd1,
		CFG_FOLD_OFS    = 3'd2,
		CFG_CONST_SCALE = 3'd3,
		CFG_EST_SCALE   = 3'd4,
		CFG_EST_OFS     = 3'd5,
		CFG_MULT_VAL    = 3'd6,
		CFG_MULT_CTRL   = 3'd7
	} cfg_index_t;

	typedef enum logic [2:0] {
		MUL_ALL   = 3'd0,
		MUL_X     = 3'd1,
		MUL_Y     = 3'd2,
		MUL_Z     = 3'd3,
		MUL_EST   = 3'd4,
		MUL_COLOR = 3'd5
	} mult_mode_t;

	// what travels with an item down the pipeline
	typedef struct packed {
		q_t [3:0]    p;
		q_t [3:0]    cv;
		logic        cvalid;
		q_t          de;
		logic [30:0] radius;
		q_t          color;
		logic [7:0]  iter;
		logic        win;
		logic        dneg;
		logic        dnz;
	} ctx_t;

	function automatic q_t sat32(input logic signed [65:0] v);
		if (v > 66'(Q_MAX))
			return Q_MAX;
		else if (v < 66'(Q_MIN))
			return Q_MIN;
		else
			return q_t'(v[31:0]);
	endfunction

	function automatic logic in_window(input logic [7:0] i, input logic [7:0] first,
			input logic [7:0] after);
		return (i >= first) && (i < after);
	endfunction

endpackage
`default_nettype wire

FILE: rtl/ft4d_sqrt.sv
// pipelined integer square root, one result bit per stage
`default_nettype none
module ft4d_sqrt (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic            in_valid,
	input  wire logic            in_big,
	input  wire logic [61:0]     in_n,
	input  wire ft4d_pkg::ctx_t  in_ctx,
	output logic                 out_valid,
	output logic [30:0]          out_len,
	output ft4d_pkg::ctx_t       out_ctx
);
	import ft4d_pkg::*;

	logic [SQ_STEPS:0] v_s;
	logic [61:0]       rem_s  [0:SQ_STEPS];
	logic [61:0]       root_s [0:SQ_STEPS];
	logic              big_s  [0:SQ_STEPS];
	ctx_t              ctx_s  [0:SQ_STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s <= '0;
		else if (en)
			v_s <= {v_s[SQ_STEPS-1:0], in_valid};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= in_n;
			root_s[0] <= '0;
			big_s[0]  <= in_big;
			ctx_s[0]  <= in_ctx;
		end
	end

	for (genvar k = 1; k <= SQ_STEPS; k++) begin : g_step
		localparam int SH = 62 - 2 * k;
		logic [62:0] trial;
		logic        ge;
		assign trial = {1'b0, root_s[k-1]} + (63'(1) << SH);
		assign ge    = {1'b0, rem_s[k-1]} >= trial;
		always_ff @(posedge clk) begin
			if (en) begin
				if (ge) begin
					rem_s[k]  <= rem_s[k-1] - trial[61:0];
					root_s[k] <= (root_s[k-1] >> 1) + (62'(1) << SH);
				end else begin
					rem_s[k]  <= rem_s[k-1];
					root_s[k] <= root_s[k-1] >> 1;
				end
				big_s[k] <= big_s[k-1];
				ctx_s[k] <= ctx_s[k-1];
			end
		end
	end

	assign out_valid = v_s[SQ_STEPS];
	assign out_len   = big_s[SQ_STEPS] ? 31'h7FFFFFFF : root_s[SQ_STEPS][30:0];
	assign out_ctx   = ctx_s[SQ_STEPS];

endmodule
`default_nettype wire

FILE: rtl/ft4d_div.sv
// pipelined restoring divider, 62-bit magnitude by 31-bit radius, 32 quotient bits
`default_nettype none
module ft4d_div (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic            in_valid,
	input  wire logic [61:0]     in_a,
	input  wire logic [30:0]     in_r,
	input  wire ft4d_pkg::ctx_t  in_ctx,
	output logic                 out_valid,
	output logic [31:0]          out_q,
	output logic                 out_ovf,
	output ft4d_pkg::ctx_t       out_ctx
);
	import ft4d_pkg::*;

	logic [DIV_STEPS:0] v_s;
	logic [30:0]        rem_s [0:DIV_STEPS];
	logic [31:0]        alo_s [0:DIV_STEPS];
	logic [31:0]        q_s   [0:DIV_STEPS];
	logic [30:0]        r_s   [0:DIV_STEPS];
	logic               ovf_s [0:DIV_STEPS];
	ctx_t               ctx_s [0:DIV_STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s <= '0;
		else if (en)
			v_s <= {v_s[DIV_STEPS-1:0], in_valid};
	end

	// quotient of 2^32 or more is flagged up front
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= {1'b0, in_a[61:32]};
			alo_s[0] <= in_a[31:0];
			q_s[0]   <= '0;
			r_s[0]   <= in_r;
			ovf_s[0] <= {1'b0, in_a[61:32]} >= in_r;
			ctx_s[0] <= in_ctx;
		end
	end

	for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
		logic [31:0] t;
		logic        ge;
		assign t  = {rem_s[k-1], alo_s[k-1][DIV_STEPS-k]};
		assign ge = t >= {1'b0, r_s[k-1]};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? 31'(t - {1'b0, r_s[k-1]}) : t[30:0];
				q_s[k]   <= {q_s[k-1][30:0], ge};
				alo_s[k] <= alo_s[k-1];
				r_s[k]   <= r_s[k-1];
				ovf_s[k] <= ovf_s[k-1];
				ctx_s[k] <= ctx_s[k-1];
			end
		end
	end

	assign out_valid = v_s[DIV_STEPS];
	assign out_q     = q_s[DIV_STEPS];
	assign out_ovf   = ovf_s[DIV_STEPS];
	assign out_ctx   = ctx_s[DIV_STEPS];

endmodule
`default_nettype wire

FILE: rtl/fold_transform_4d_step_unit.sv
// 4d fold transform step: fold or length, constant vector, estimate rescale, multiplier
// throughput: one item per cycle while not stalled; two 32-stage square roots and a
// 33-stage divider in line
// the whole pipeline stalls only while an output item waits and m_tready is low
// reset (arst_n low, asynchronous) clears all valid bits and loads register defaults
`default_nettype none
module fold_transform_4d_step_unit (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// point_x, point_y, point_z, point_w, estimate_in, radius_in, color_in, iteration
	input  wire logic [231:0] s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// result_x, result_y, result_z, result_w, estimate_out, color_out,
	// const_x, const_y, const_z, const_w, const_valid
	output logic [327:0]      m_tdata,
	input  wire logic         cfg_we,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [63:0]  cfg_data
);
	import ft4d_pkg::*;

	logic        en;
	logic [15:0] wb_q;
	logic [4:0]  mf_q;
	logic [63:0] fo_q;
	logic [63:0] cs_q;
	q_t          es_q;
	q_t          eo_q;
	q_t          mv_q;
	logic [18:0] mc_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wb_q <= 16'hFF00;
			mf_q <= '0;
			fo_q <= '0;
			cs_q <= 64'h1000100010001000;
			es_q <= q_t'(32'h01000000);
			eo_q <= '0;
			mv_q <= q_t'(32'h01000000);
			mc_q <= 19'h7F800;
		end else if (cfg_we) begin
			case (cfg_index_t'(cfg_index))
				CFG_WINDOW:      wb_q <= cfg_data[15:0];
				CFG_MODE:        mf_q <= cfg_data[4:0];
				CFG_FOLD_OFS:    fo_q <= cfg_data;
				CFG_CONST_SCALE: cs_q <= cfg_data;
				CFG_EST_SCALE:   es_q <= q_t'(cfg_data[31:0]);
				CFG_EST_OFS:     eo_q <= q_t'(cfg_data[31:0]);
				CFG_MULT_VAL:    mv_q <= q_t'(cfg_data[31:0]);
				CFG_MULT_CTRL:   mc_q <= cfg_data[18:0];
				default:         ;
			endcase
		end
	end

	logic v_s1, v_s2, v_s3, v_s5, v_s6, v_s7, v_s8, v_s10, v_s13, v_s14, v_s15, v_s16, v_s17;
	logic v_sq1, v_sq2, v_dv;

	assign en       = !v_s17 || m_tready;
	assign s_tready = en;
	assign m_tvalid = v_s17;

	// stage 1: capture and mix
	ctx_t ctx_in, ctx_s1;
	q_t   mix_c [4];
	q_t   mix_s1 [4];

	always_comb begin
		logic signed [33:0] xe, ye, ze;
		logic signed [33:0] m [4];
		ctx_in        = '0;
		ctx_in.p[0]   = q_t'(s_tdata[31:0]);
		ctx_in.p[1]   = q_t'(s_tdata[63:32]);
		ctx_in.p[2]   = q_t'(s_tdata[95:64]);
		ctx_in.p[3]   = q_t'(s_tdata[127:96]);
		ctx_in.de     = q_t'(s_tdata[159:128]);
		ctx_in.radius = s_tdata[190:160];
		ctx_in.color  = q_t'(s_tdata[222:191]);
		ctx_in.iter   = s_tdata[230:223];
		ctx_in.win    = in_window(s_tdata[230:223], wb_q[7:0], wb_q[15:8]);
		xe   = 34'(signed'(ctx_in.p[0]));
		ye   = 34'(signed'(ctx_in.p[1]));
		ze   = 34'(signed'(ctx_in.p[2]));
		m[0] = xe + ye + ze;
		m[1] = -xe - ye + ze;
		m[2] = -xe + ye - ze;
		m[3] = xe - ye - ze;
		for (int k = 0; k < 4; k++)
			mix_c[k] = sat32(66'(m[k] < 0 ? -m[k] : m[k]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (en)
			v_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s1 <= ctx_in;
			mix_s1 <= mix_c;
		end
	end

	// stage 2: offset fold, squares of the incoming point
	ctx_t              ctx2_c, ctx_s2;
	logic [62:0]       sq_c [4];
	logic [62:0]       sq_s2 [4];

	always_comb begin
		logic signed [33:0] offw, d;
		logic signed [63:0] pr;
		ctx2_c = ctx_s1;
		for (int k = 0; k < 4; k++) begin
			offw = 34'(signed'(fo_q[16*k +: 16])) <<< 12;
			d    = 34'(mix_s1[k]) - offw;
			if (ctx_s1.win && !mf_q[MF_LENGTH])
				ctx2_c.p[k] = sat32(66'(d < 0 ? -d : d));
			pr       = signed'(ctx_s1.p[k]) * signed'(ctx_s1.p[k]);
			sq_c[k]  = pr[62:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (en)
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s2 <= ctx2_c;
			sq_s2  <= sq_c;
		end
	end

	// stage 3: sum of squares
	ctx_t        ctx_s3;
	logic [64:0] sum_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else if (en)
			v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s3 <= ctx_s2;
			sum_s3 <= 65'(sq_s2[0]) + 65'(sq_s2[1]) + 65'(sq_s2[2]) + 65'(sq_s2[3]);
		end
	end

	// length of the incoming point
	logic [30:0] len_sq1;
	ctx_t        ctx_sq1;

	ft4d_sqrt u_sqrt_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.in_big    (|sum_s3[64:62]),
		.in_n      (sum_s3[61:0]),
		.in_ctx    (ctx_s3),
		.out_valid (v_sq1),
		.out_len   (len_sq1),
		.out_ctx   (ctx_sq1)
	);

	// stage 5: length mode w, constant vector products
	ctx_t               ctx5_c, ctx_s5;
	logic signed [47:0] cp_c [4];
	logic signed [47:0] cp_s5 [4];

	always_comb begin
		ctx5_c = ctx_sq1;
		if (ctx_sq1.win && mf_q[MF_LENGTH])
			ctx5_c.p[3] = q_t'({1'b0, len_sq1});
		for (int k = 0; k < 4; k++)
			cp_c[k] = signed'(ctx5_c.p[k]) * signed'(cs_q[16*k +: 16]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s5 <= 1'b0;
		else if (en)
			v_s5 <= v_sq1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s5 <= ctx5_c;
			cp_s5  <= cp_c;
		end
	end

	// stage 6: constant vector, zero point
	ctx_t ctx6_c, ctx_s6;

	always_comb begin
		ctx6_c = ctx_s5;
		for (int k = 0; k < 4; k++) begin
			if (ctx_s5.win && mf_q[MF_CONST])
				ctx6_c.cv[k] = sat32(66'(cp_s5[k] >>> 12));
			else
				ctx6_c.cv[k] = '0;
			if (ctx_s5.win && mf_q[MF_ZERO])
				ctx6_c.p[k] = '0;
		end
		ctx6_c.cvalid = ctx_s5.win && mf_q[MF_CONST];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s6 <= 1'b0;
		else if (en)
			v_s6 <= v_s5;
	end

	always_ff @(posedge clk) begin
		if (en)
			ctx_s6 <= ctx6_c;
	end

	// stage 7: squares of the new point
	ctx_t        ctx_s7;
	logic [62:0] sq2_c [4];
	logic [62:0] sq2_s7 [4];

	always_comb begin
		logic signed [63:0] pr;
		for (int k = 0; k < 4; k++) begin
			pr       = signed'(ctx_s6.p[k]) * signed'(ctx_s6.p[k]);
			sq2_c[k] = pr[62:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s7 <= 1'b0;
		else if (en)
			v_s7 <= v_s6;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s7 <= ctx_s6;
			sq2_s7 <= sq2_c;
		end
	end

	// stage 8: sum of squares
	ctx_t        ctx_s8;
	logic [64:0] sum2_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s8 <= 1'b0;
		else if (en)
			v_s8 <= v_s7;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s8  <= ctx_s7;
			sum2_s8 <= 65'(sq2_s7[0]) + 65'(sq2_s7[1]) + 65'(sq2_s7[2]) + 65'(sq2_s7[3]);
		end
	end

	logic [30:0] len_sq2;
	ctx_t        ctx_sq2;

	ft4d_sqrt u_sqrt_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s8),
		.in_big    (|sum2_s8[64:62]),
		.in_n      (sum2_s8[61:0]),
		.in_ctx    (ctx_s8),
		.out_valid (v_sq2),
		.out_len   (len_sq2),
		.out_ctx   (ctx_sq2)
	);

	// stage 10: estimate times new length
	ctx_t               ctx_s10;
	logic signed [63:0] num_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s10 <= 1'b0;
		else if (en)
			v_s10 <= v_sq2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s10 <= ctx_sq2;
			num_s10 <= signed'(ctx_sq2.de) * signed'({1'b0, len_sq2});
		end
	end

	ctx_t               ctxd_c;
	logic signed [63:0] numabs_c;

	always_comb begin
		ctxd_c      = ctx_s10;
		ctxd_c.dneg = num_s10 < 0;
		ctxd_c.dnz  = num_s10 != 0;
		numabs_c    = num_s10 < 0 ? -num_s10 : num_s10;
	end

	logic [31:0] q_dv;
	logic        ovf_dv;
	ctx_t        ctx_dv;

	ft4d_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s10),
		.in_a      (numabs_c[61:0]),
		.in_r      (ctx_s10.radius),
		.in_ctx    (ctxd_c),
		.out_valid (v_dv),
		.out_q     (q_dv),
		.out_ovf   (ovf_dv),
		.out_ctx   (ctx_dv)
	);

	// stage 13: rescaled estimate
	ctx_t ctx13_c, ctx_s13;

	always_comb begin
		ctx13_c = ctx_dv;
		if (!mf_q[MF_NOTWK]) begin
			if (ctx_dv.radius == '0)
				ctx13_c.de = !ctx_dv.dnz ? '0 : (ctx_dv.dneg ? Q_MIN : Q_MAX);
			else if (ctx_dv.dneg)
				ctx13_c.de = (ovf_dv || q_dv > 32'h80000000) ? Q_MIN : q_t'(-q_dv);
			else
				ctx13_c.de = (ovf_dv || q_dv[31]) ? Q_MAX : q_t'(q_dv);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s13 <= 1'b0;
		else if (en)
			v_s13 <= v_dv;
	end

	always_ff @(posedge clk) begin
		if (en)
			ctx_s13 <= ctx13_c;
	end

	// stage 14/15: estimate scale and offset
	ctx_t               ctx_s14, ctx15_c, ctx_s15;
	logic signed [63:0] esp_s14;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s14 <= 1'b0;
			v_s15 <= 1'b0;
		end else if (en) begin
			v_s14 <= v_s13;
			v_s15 <= v_s14;
		end
	end

	always_comb begin
		ctx15_c    = ctx_s14;
		ctx15_c.de = sat32(66'(esp_s14 >>> 24) + 66'(eo_q));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s14 <= ctx_s13;
			esp_s14 <= signed'(ctx_s13.de) * es_q;
			ctx_s15 <= ctx15_c;
		end
	end

	// stage 16: general multiplier products
	ctx_t               ctx_s16;
	logic               mul_s16;
	logic signed [63:0] pm_c [4];
	logic signed [63:0] pm_s16 [4];
	logic signed [64:0] pd_c, pd_s16;
	logic signed [63:0] pc_s16;
	logic signed [63:0] pe_s16;
	logic signed [32:0] absv_c;

	always_comb begin
		absv_c = mv_q < 0 ? -33'(mv_q) : 33'(mv_q);
		pd_c   = signed'(ctx_s15.de) * absv_c;
		for (int k = 0; k < 4; k++)
			pm_c[k] = signed'(ctx_s15.p[k]) * mv_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s16 <= 1'b0;
		else if (en)
			v_s16 <= v_s15;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s16 <= ctx_s15;
			mul_s16 <= mf_q[MF_MULT] && in_window(ctx_s15.iter, mc_q[10:3], mc_q[18:11]);
			pm_s16  <= pm_c;
			pd_s16  <= pd_c;
			pc_s16  <= signed'(ctx_s15.color) * mv_q;
			pe_s16  <= signed'(ctx_s15.de) * mv_q;
		end
	end

	// stage 17: output register
	ctx_t ctx17_c, ctx_s17;

	always_comb begin
		ctx17_c = ctx_s16;
		if (mul_s16) begin
			case (mult_mode_t'(mc_q[2:0]))
				MUL_X:     ctx17_c.p[0]  = sat32(66'(pm_s16[0] >>> 24));
				MUL_Y:     ctx17_c.p[1]  = sat32(66'(pm_s16[1] >>> 24));
				MUL_Z:     ctx17_c.p[2]  = sat32(66'(pm_s16[2] >>> 24));
				MUL_EST:   ctx17_c.de    = sat32(66'(pe_s16 >>> 24));
				MUL_COLOR: ctx17_c.color = sat32(66'(pc_s16 >>> 24));
				default: begin
					for (int k = 0; k < 4; k++)
						ctx17_c.p[k] = sat32(66'(pm_s16[k] >>> 24));
					ctx17_c.de = sat32(66'(pd_s16 >>> 24));
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s17 <= 1'b0;
		else if (en)
			v_s17 <= v_s16;
	end

	always_ff @(posedge clk) begin
		if (en)
			ctx_s17 <= ctx17_c;
	end

	assign m_tdata = {7'b0, ctx_s17.cvalid, ctx_s17.cv[3], ctx_s17.cv[2], ctx_s17.cv[1],
		ctx_s17.cv[0], ctx_s17.color, ctx_s17.de, ctx_s17.p[3], ctx_s17.p[2],
		ctx_s17.p[1], ctx_s17.p[0]};

	// no constant vector means all its components are zero
	a_const_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !ctx_s17.cvalid) |-> (ctx_s17.cv == '0))
		else $error("constant vector not cleared");

	// a stalled output freezes the pipeline
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> ($stable(v_s1) && $stable(v_s10) && $stable(v_s16)))
		else $error("pipeline moved during stall");

	// items advance one stage per enabled cycle
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(!m_tvalid || m_tready) |=> (v_s2 == $past(v_s1) && v_s17 == $past(v_s16)))
		else $error("valid bit lost or repeated");

endmodule
`default_nettype wire
